/* src/dbd_pkg.sv */
// Shared constants and register codes of the detector box decoder.
`default_nettype none
package dbd_pkg;

  localparam int MAX_CLASSES = 80;
  localparam int CNT_W       = $clog2(MAX_CLASSES + 1);

  localparam int RAW_W   = 8;
  localparam int SCALE_W = 24;
  localparam int THR_W   = 7;
  localparam int SIZE_W  = 11;
  localparam int SCORE_W = 8;
  localparam int CLS_W   = 7;
  localparam int PIX_W   = 16;
  localparam int FRAC_W  = 16;

  localparam int OPA_W  = 12;
  localparam int PROD_W = OPA_W + SCALE_W + 1;
  localparam int INT_W  = PROD_W - FRAC_W;
  localparam int WH_W   = 18;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THRESHOLD  = 3'd0,
    REG_SCORE_SCALE      = 3'd1,
    REG_SCORE_ZERO_POINT = 3'd2,
    REG_BOX_SCALE        = 3'd3,
    REG_BOX_ZERO_POINT   = 3'd4,
    REG_MODEL_SIZE       = 3'd5,
    REG_HORIZ_SCALE      = 3'd6,
    REG_VERT_SCALE       = 3'd7
  } cfg_reg_t;

  localparam logic MODE_SCORE = 1'b0;
  localparam logic MODE_BOX   = 1'b1;

endpackage
`default_nettype wire

/* src/detector_box_decode.sv */
// Detector box decoder: int8 score and box items in, one decoded box result out.
// A box arrives as class-score items (tuser 0) closed by one box item (tuser 1).
// All scaling runs through one shared 12x24 multiplier with a registered
// product, stepped by a small sequencer. For a score item the accept cycle
// multiplies and the next compares against the running best; a score item
// past the class limit is dropped in its accept cycle. A box item with no
// winning class is finished in its accept cycle; one with a winner takes
// eight multiplier passes plus truncate, clip and hand-off steps, and waits
// in the hand-off step while the previous result has not yet been taken.
// Score items are taken while a result waits at the output.
`default_nettype none
module detector_box_decode (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // cfg: register index per the register list, narrow registers take the low data bits
  input  wire logic                             cfg_we,
  input  wire logic [dbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dbd_pkg::SCALE_W-1:0]      cfg_data,
  // tdata: class_score[7:0], left_raw[15:8], top_raw[23:16],
  //        right_raw[31:24], bottom_raw[39:32]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [dbd_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: mode[0]
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tdata: best_score_out[7:0], class_index[14:8], center_x[30:15],
  //        center_y[46:31], box_width[62:47], box_height[78:63], zero[79]
  output logic [dbd_pkg::OUT_DATA_W-1:0]        out_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCORE,
    ST_TLX, ST_W, ST_TLY, ST_H, ST_HT, ST_CY,
    ST_SCX, ST_SCY, ST_SW, ST_SH, ST_SHR, ST_EMIT
  } state_t;

  // configuration
  logic [dbd_pkg::THR_W-1:0]          thr_r;
  logic [dbd_pkg::SCALE_W-1:0]        sscale_r;
  logic signed [dbd_pkg::RAW_W-1:0]   szp_r;
  logic [dbd_pkg::SCALE_W-1:0]        bscale_r;
  logic signed [dbd_pkg::RAW_W-1:0]   bzp_r;
  logic [dbd_pkg::SIZE_W-1:0]         msize_r;
  logic [dbd_pkg::SCALE_W-1:0]        hscale_r;
  logic [dbd_pkg::SCALE_W-1:0]        vscale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= dbd_pkg::THR_W'(50);
      sscale_r <= dbd_pkg::SCALE_W'(65536);
      szp_r    <= '0;
      bscale_r <= dbd_pkg::SCALE_W'(65536);
      bzp_r    <= '0;
      msize_r  <= dbd_pkg::SIZE_W'(256);
      hscale_r <= dbd_pkg::SCALE_W'(65536);
      vscale_r <= dbd_pkg::SCALE_W'(65536);
    end else if (cfg_we) begin
      case (dbd_pkg::cfg_reg_t'(cfg_index))
        dbd_pkg::REG_SCORE_THRESHOLD:  thr_r    <= cfg_data[dbd_pkg::THR_W-1:0];
        dbd_pkg::REG_SCORE_SCALE:      sscale_r <= cfg_data;
        dbd_pkg::REG_SCORE_ZERO_POINT: szp_r    <= cfg_data[dbd_pkg::RAW_W-1:0];
        dbd_pkg::REG_BOX_SCALE:        bscale_r <= cfg_data;
        dbd_pkg::REG_BOX_ZERO_POINT:   bzp_r    <= cfg_data[dbd_pkg::RAW_W-1:0];
        dbd_pkg::REG_MODEL_SIZE:       msize_r  <= cfg_data[dbd_pkg::SIZE_W-1:0];
        dbd_pkg::REG_HORIZ_SCALE:      hscale_r <= cfg_data;
        dbd_pkg::REG_VERT_SCALE:       vscale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state_r;

  logic [dbd_pkg::SCORE_W-1:0]  best_r;
  logic [dbd_pkg::CLS_W-1:0]    cls_r;
  logic                         found_r;
  logic [dbd_pkg::CNT_W-1:0]    cnt_r;

  logic signed [dbd_pkg::RAW_W-1:0] l_r, t_r, rr_r, b_r;
  logic signed [dbd_pkg::PROD_W-1:0] prod_r, tlx_r, tly_r;
  logic signed [dbd_pkg::WH_W-1:0]   w_r, h_r;
  logic [dbd_pkg::SIZE_W-1:0]        cxc_r, cyc_r, wc_r, hc_r;
  logic [dbd_pkg::PIX_W-1:0]         res_cx_r, res_cy_r, res_w_r, res_h_r;

  logic                              out_valid_r;
  logic [dbd_pkg::OUT_DATA_W-1:0]    out_data_r;

  logic in_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic signed [dbd_pkg::RAW_W-1:0] in_score;
  assign in_score = in_tdata[7:0];

  // shared multiplier operands
  logic signed [dbd_pkg::RAW_W:0]    diff;
  logic signed [dbd_pkg::OPA_W-1:0]  mul_a;
  logic [dbd_pkg::SCALE_W-1:0]       mul_b;
  logic signed [dbd_pkg::PROD_W-1:0] product;

  always_comb begin
    diff  = '0;
    mul_a = '0;
    mul_b = bscale_r;
    case (state_r)
      ST_IDLE: begin
        diff  = {in_score[dbd_pkg::RAW_W-1], in_score} - {szp_r[dbd_pkg::RAW_W-1], szp_r};
        mul_a = {{(dbd_pkg::OPA_W-dbd_pkg::RAW_W-1){diff[dbd_pkg::RAW_W]}}, diff};
        mul_b = sscale_r;
      end
      ST_TLX: begin
        diff  = {l_r[dbd_pkg::RAW_W-1], l_r} - {bzp_r[dbd_pkg::RAW_W-1], bzp_r};
        mul_a = {{(dbd_pkg::OPA_W-dbd_pkg::RAW_W-1){diff[dbd_pkg::RAW_W]}}, diff};
      end
      ST_W: begin
        diff  = {rr_r[dbd_pkg::RAW_W-1], rr_r} - {l_r[dbd_pkg::RAW_W-1], l_r};
        mul_a = {{(dbd_pkg::OPA_W-dbd_pkg::RAW_W-1){diff[dbd_pkg::RAW_W]}}, diff};
      end
      ST_TLY: begin
        diff  = {t_r[dbd_pkg::RAW_W-1], t_r} - {bzp_r[dbd_pkg::RAW_W-1], bzp_r};
        mul_a = {{(dbd_pkg::OPA_W-dbd_pkg::RAW_W-1){diff[dbd_pkg::RAW_W]}}, diff};
      end
      ST_H: begin
        diff  = {b_r[dbd_pkg::RAW_W-1], b_r} - {t_r[dbd_pkg::RAW_W-1], t_r};
        mul_a = {{(dbd_pkg::OPA_W-dbd_pkg::RAW_W-1){diff[dbd_pkg::RAW_W]}}, diff};
      end
      ST_SCX: begin
        mul_a = {1'b0, cxc_r};
        mul_b = hscale_r;
      end
      ST_SCY: begin
        mul_a = {1'b0, cyc_r};
        mul_b = vscale_r;
      end
      ST_SW: begin
        mul_a = {1'b0, wc_r};
        mul_b = hscale_r;
      end
      ST_SH: begin
        mul_a = {1'b0, hc_r};
        mul_b = vscale_r;
      end
      default: ;
    endcase
    product = mul_a * $signed({1'b0, mul_b});
  end

  // score from the registered product: truncate, saturate to 0..255
  logic [dbd_pkg::SCORE_W-1:0] score;
  logic [dbd_pkg::SCORE_W-1:0] best_base;
  always_comb begin
    if (prod_r[dbd_pkg::PROD_W-1])
      score = '0;
    else if (|prod_r[dbd_pkg::PROD_W-2:dbd_pkg::FRAC_W+dbd_pkg::SCORE_W])
      score = '1;
    else
      score = prod_r[dbd_pkg::FRAC_W+dbd_pkg::SCORE_W-1:dbd_pkg::FRAC_W];
    best_base = (cnt_r == '0) ? {1'b0, thr_r} : best_r;
  end

  // truncate a Q.16 product toward zero
  logic signed [dbd_pkg::PROD_W-1:0] trunc_sum;
  logic signed [dbd_pkg::INT_W-1:0]  trunc_int;
  always_comb begin
    trunc_sum = prod_r + (prod_r[dbd_pkg::PROD_W-1] ?
                dbd_pkg::PROD_W'(16'hFFFF) : '0);
    trunc_int = trunc_sum[dbd_pkg::PROD_W-1:dbd_pkg::FRAC_W];
  end

  // center: top-left plus the floor-halved extent in whole pixels
  logic signed [dbd_pkg::WH_W-1:0]   half;
  logic signed [dbd_pkg::PROD_W-1:0] base_q;
  logic signed [dbd_pkg::PROD_W-1:0] ctr_sum;
  always_comb begin
    half    = (state_r == ST_H) ? (w_r >>> 1) : (h_r >>> 1);
    base_q  = (state_r == ST_H) ? tlx_r : tly_r;
    ctr_sum = base_q + {{(dbd_pkg::INT_W-dbd_pkg::WH_W){half[dbd_pkg::WH_W-1]}}, half,
                        16'h0000};
  end

  function automatic logic [dbd_pkg::SIZE_W-1:0] clip_int(
    input logic signed [dbd_pkg::INT_W-1:0] v,
    input logic [dbd_pkg::SIZE_W-1:0]       lim
  );
    logic [dbd_pkg::SIZE_W-1:0] res;
    if (v[dbd_pkg::INT_W-1])
      res = '0;
    else if (v > $signed({{(dbd_pkg::INT_W-dbd_pkg::SIZE_W){1'b0}}, lim}))
      res = lim;
    else
      res = v[dbd_pkg::SIZE_W-1:0];
    return res;
  endfunction

  logic [dbd_pkg::SIZE_W-1:0] ctr_clip, ext_clip;
  logic signed [dbd_pkg::WH_W-1:0] ext_sel;
  always_comb begin
    ext_sel  = (state_r == ST_H) ? w_r : h_r;
    ctr_clip = clip_int(ctr_sum[dbd_pkg::PROD_W-1:dbd_pkg::FRAC_W], msize_r);
    ext_clip = clip_int({{(dbd_pkg::INT_W-dbd_pkg::WH_W){ext_sel[dbd_pkg::WH_W-1]}}, ext_sel},
                        msize_r);
  end

  // scaled pixel value, saturated to 16 bits
  logic [dbd_pkg::PIX_W-1:0] pix;
  always_comb begin
    if (|prod_r[dbd_pkg::PROD_W-1:dbd_pkg::FRAC_W+dbd_pkg::PIX_W])
      pix = '1;
    else
      pix = prod_r[dbd_pkg::FRAC_W+dbd_pkg::PIX_W-1:dbd_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    prod_r <= product;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      best_r      <= '0;
      cls_r       <= '0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && state_r != ST_EMIT)
        out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_tuser == dbd_pkg::MODE_SCORE) begin
              if (cnt_r < dbd_pkg::CNT_W'(dbd_pkg::MAX_CLASSES))
                state_r <= ST_SCORE;
            end else if (found_r) begin
              l_r     <= in_tdata[15:8];
              t_r     <= in_tdata[23:16];
              rr_r    <= in_tdata[31:24];
              b_r     <= in_tdata[39:32];
              state_r <= ST_TLX;
            end else begin
              cls_r   <= '0;
              cnt_r   <= '0;
            end
          end
        end
        ST_SCORE: begin
          if (score > best_base) begin
            best_r  <= score;
            cls_r   <= cnt_r[dbd_pkg::CLS_W-1:0];
            found_r <= 1'b1;
          end else begin
            best_r  <= best_base;
          end
          cnt_r   <= cnt_r + dbd_pkg::CNT_W'(1);
          state_r <= ST_IDLE;
        end
        ST_TLX: state_r <= ST_W;
        ST_W: begin
          tlx_r   <= prod_r;
          state_r <= ST_TLY;
        end
        ST_TLY: begin
          w_r     <= trunc_int[dbd_pkg::WH_W-1:0];
          state_r <= ST_H;
        end
        ST_H: begin
          tly_r   <= prod_r;
          cxc_r   <= ctr_clip;
          wc_r    <= ext_clip;
          state_r <= ST_HT;
        end
        ST_HT: begin
          h_r     <= trunc_int[dbd_pkg::WH_W-1:0];
          state_r <= ST_CY;
        end
        ST_CY: begin
          cyc_r   <= ctr_clip;
          hc_r    <= ext_clip;
          state_r <= ST_SCX;
        end
        ST_SCX: state_r <= ST_SCY;
        ST_SCY: begin
          res_cx_r <= pix;
          state_r  <= ST_SW;
        end
        ST_SW: begin
          res_cy_r <= pix;
          state_r  <= ST_SH;
        end
        ST_SH: begin
          res_w_r <= pix;
          state_r <= ST_SHR;
        end
        ST_SHR: begin
          res_h_r <= pix;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, res_h_r, res_w_r, res_cy_r, res_cx_r, cls_r, best_r};
            cls_r       <= '0;
            found_r     <= 1'b0;
            cnt_r       <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (state_r == ST_IDLE && in_fire && in_tuser == dbd_pkg::MODE_BOX && !found_r)
        found_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire
